// ===== sv/bbi_pkg.sv =====
package bbi_pkg;

  // Configuration register indexes
  localparam logic [1:0] CFG_FRAME_SIZE = 2'd0;
  localparam logic [1:0] CFG_MULT_SEL   = 2'd1;
  localparam logic [1:0] CFG_DIRECTION  = 2'd2;

  localparam int CFG_W  = 14;
  localparam int CIDX_W = 2;

  // Reset values and limits of the frame size
  localparam logic [CFG_W-1:0] FRAME_SIZE_RESET = 14'd1024;
  localparam int               FRAME_MIN        = 4;

  // Multiplier selector codes
  localparam logic [1:0] MSEL_5  = 2'd0;
  localparam logic [1:0] MSEL_13 = 2'd1;
  localparam logic [1:0] MSEL_21 = 2'd2;

  // Recurrence multipliers
  localparam int         MULT_W  = 5;
  localparam logic [4:0] MULT_5  = 5'd5;
  localparam logic [4:0] MULT_13 = 5'd13;
  localparam logic [4:0] MULT_21 = 5'd21;

  // Direction codes
  localparam logic DIR_INTERLEAVE   = 1'b0;
  localparam logic DIR_DEINTERLEAVE = 1'b1;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_GEN,
    ST_DONE
  } ctrl_state_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic access;
    logic load_out;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic perm_ok;
    logic out_free;
  } dp_status_t;

endpackage

// ===== sv/bbi_ram.sv =====
module bbi_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/bbi_ctrl.sv =====
module bbi_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  bbi_pkg::dp_status_t status,
  output bbi_pkg::ctrl_cmd_t  cmd
);

  bbi_pkg::ctrl_state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bbi_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next   = state;
    cmd          = '0;
    in_stall     = 1'b1;
    unique case (state)
      bbi_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = bbi_pkg::ST_GEN;
        end
      end
      bbi_pkg::ST_GEN: begin
        // datapath steps the recurrence on its own until the value is in range
        if (status.perm_ok) begin
          cmd.access = 1'b1;
          state_next = bbi_pkg::ST_DONE;
        end
      end
      bbi_pkg::ST_DONE: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          in_stall     = 1'b0;
          if (in_valid) begin
            cmd.accept = 1'b1;
            state_next = bbi_pkg::ST_GEN;
          end else begin
            state_next = bbi_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_next = bbi_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/bbi_dp.sv =====
module bbi_dp #(
  parameter int MAX_FRAME = 8192
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [bbi_pkg::CIDX_W-1:0] cfg_index,
  input  logic [bbi_pkg::CFG_W-1:0]  cfg_data,
  input  logic                       in_bit,
  input  bbi_pkg::ctrl_cmd_t         cmd,
  output bbi_pkg::dp_status_t        status,
  output logic                       out_bit,
  output logic                       out_valid,
  output logic                       out_last,
  output logic                       result_valid,
  input  logic                       result_stall
);

  localparam int PW = (MAX_FRAME > 1) ? $clog2(MAX_FRAME) : 1;  // position bits
  localparam int NW = PW + 1;                                   // frame size / modulus bits
  localparam int PRW = NW + bbi_pkg::MULT_W;                    // product bits
  localparam int AW = PW + 1;                                   // bank select + position
  localparam int RAM_DEPTH = 2 ** AW;

  // Configuration registers
  logic [bbi_pkg::CFG_W-1:0] frame_size;
  logic [1:0]                multiplier_select;
  logic                      direction;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_size        <= bbi_pkg::FRAME_SIZE_RESET;
      multiplier_select <= bbi_pkg::MSEL_5;
      direction         <= bbi_pkg::DIR_INTERLEAVE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bbi_pkg::CFG_FRAME_SIZE: frame_size        <= cfg_data;
        bbi_pkg::CFG_MULT_SEL:   multiplier_select <= cfg_data[1:0];
        bbi_pkg::CFG_DIRECTION:  direction         <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Effective frame size, modulus mask and increment
  logic [31:0]   fs_wide;
  logic [NW-1:0] n_eff;
  logic [NW-1:0] mask;
  logic [NW-1:0] q_inc;
  logic [4:0]    t0;

  always_comb begin
    fs_wide = 32'(frame_size);
    if (fs_wide < 32'(bbi_pkg::FRAME_MIN)) begin
      fs_wide = 32'(bbi_pkg::FRAME_MIN);
    end
    if (fs_wide > 32'(MAX_FRAME)) begin
      fs_wide = 32'(MAX_FRAME);
    end
    n_eff = fs_wide[NW-1:0];
  end

  // s - 1: all ones up to the top set bit of n
  always_comb begin
    for (int i = 0; i < NW; i++) begin
      mask[i] = |(n_eff >> i);
    end
  end

  assign q_inc = mask >> 2;

  always_comb begin
    unique case (multiplier_select)
      bbi_pkg::MSEL_13: t0 = bbi_pkg::MULT_13;
      bbi_pkg::MSEL_21: t0 = bbi_pkg::MULT_21;
      default:          t0 = bbi_pkg::MULT_5;
    endcase
  end

  // Frame state
  logic [PW-1:0] bit_position;
  logic [PW-1:0] last_perm_value;
  logic          write_bank;
  logic          have_previous_frame;
  logic [NW-1:0] perm_val;
  logic          in_bit_r;
  logic          flag_valid;
  logic          flag_last;

  // One recurrence step: (t0 * v + q) mod s
  logic [NW-1:0]  step_src;
  logic [PRW-1:0] step_sum;
  logic [NW-1:0]  step_val;

  assign step_src = cmd.accept ? (NW'(last_perm_value) & mask) : perm_val;
  assign step_sum = PRW'(step_src) * PRW'(t0) + PRW'(q_inc);
  assign step_val = step_sum[NW-1:0] & mask;

  assign status.perm_ok = perm_val < n_eff;

  logic last_pos;
  assign last_pos = NW'(bit_position) >= (n_eff - NW'(1));

  // Generator register
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      in_bit_r <= in_bit;
      perm_val <= (bit_position == '0) ? '0 : step_val;
    end else if (!status.perm_ok) begin
      perm_val <= step_val;
    end
  end

  // Position, previous value and bank bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      bit_position        <= '0;
      last_perm_value     <= '0;
      write_bank          <= 1'b0;
      have_previous_frame <= 1'b0;
    end else if (cmd.access) begin
      if (last_pos) begin
        bit_position        <= '0;
        last_perm_value     <= '0;
        write_bank          <= ~write_bank;
        have_previous_frame <= 1'b1;
      end else begin
        bit_position    <= bit_position + PW'(1);
        last_perm_value <= perm_val[PW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.access) begin
      flag_valid <= have_previous_frame;
      flag_last  <= last_pos;
    end
  end

  // Bank addressing: write current bank, read the other one
  logic [PW-1:0] seq_addr;
  logic [PW-1:0] perm_addr;
  logic [AW-1:0] ram_waddr;
  logic [AW-1:0] ram_raddr;
  logic          ram_rdata;

  assign seq_addr  = bit_position;
  assign perm_addr = perm_val[PW-1:0];

  always_comb begin
    if (direction == bbi_pkg::DIR_DEINTERLEAVE) begin
      ram_waddr = {write_bank, perm_addr};
      ram_raddr = {~write_bank, seq_addr};
    end else begin
      ram_waddr = {write_bank, seq_addr};
      ram_raddr = {~write_bank, perm_addr};
    end
  end

  bbi_ram #(
    .WIDTH (1),
    .DEPTH (RAM_DEPTH)
  ) u_banks (
    .clk   (clk),
    .we    (cmd.access),
    .waddr (ram_waddr),
    .wdata (in_bit_r),
    .re    (cmd.access),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Output register
  assign status.out_free = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.load_out) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_bit   <= flag_valid & ram_rdata;
      out_valid <= flag_valid;
      out_last  <= flag_last;
    end
  end

endmodule

// ===== sv/block_bit_interleaver.sv =====
// Frame bit interleaver/deinterleaver with two ping-pong banks. One bit goes in per
// transaction and one bit of the previous frame comes out, out_valid marking it once
// a full frame has been stored. After a bit is accepted, the permutation generator steps
// until it lands in range, once for every out-of-range value it skips, and the banks are
// then accessed before a new bit is taken. The modulus is at most twice the frame size.
// A finished bit waits in an output register, so the next bit is accepted while it is
// held. Bank storage comes up unwritten and needs no clearing pass. Configuration is to
// be written by the user only while the block is idle; the block does not enforce this.
module block_bit_interleaver #(
  parameter int MAX_FRAME = 8192
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [bbi_pkg::CIDX_W-1:0] cfg_index,
  input  logic [bbi_pkg::CFG_W-1:0]  cfg_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_bit,
  output logic                       result_valid,
  input  logic                       result_stall,
  output logic                       out_bit,
  output logic                       out_valid,
  output logic                       out_last
);

  bbi_pkg::ctrl_cmd_t  cmd;
  bbi_pkg::dp_status_t status;

  bbi_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  bbi_dp #(
    .MAX_FRAME (MAX_FRAME)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_bit       (in_bit),
    .cmd          (cmd),
    .status       (status),
    .out_bit      (out_bit),
    .out_valid    (out_valid),
    .out_last     (out_last),
    .result_valid (result_valid),
    .result_stall (result_stall)
  );

  // A bit being worked on blocks the next transaction in the cycle after it is accepted
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted while previous bit still in generation");

  // Memory access only with an in-range permutation value
  a_access_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.access |-> status.perm_ok)
    else $error("bank access with out-of-range permutation value");

  // Output register never overwritten while a held result is stalled
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> status.out_free)
    else $error("output register loaded while result stalled");

  // Every new result follows a load command
  a_result_from_load: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(cmd.load_out))
    else $error("result valid without load");

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  localparam int MAX_FRAME    = 8192;
  localparam int PREFILL      = 256;
  localparam int RANDOM_BITS  = 1400;
  localparam int IDLE_LIMIT   = 40000;
  localparam int TAIL_CYCLES  = 40;
  localparam int REPORT_LIMIT = 10;

  // One output transaction of the interleaver
  typedef struct packed {
    logic out_bit;
    logic out_valid;
    logic out_last;
  } bit_result_t;

  typedef enum logic {
    ROW_WRITE,
    ROW_BITS
  } row_kind_t;

  // One row of the directed plan
  typedef struct {
    row_kind_t                  kind;
    logic [bbi_pkg::CIDX_W-1:0] reg_idx;
    logic [bbi_pkg::CFG_W-1:0]  reg_val;
    int                         count;
    logic                       typed;
    logic                       fixed_bit;
    bit_result_t                typed_exp;
  } stim_row_t;

  logic                       clk          = 1'b0;
  logic                       rst          = 1'b1;
  logic                       cfg_we       = 1'b0;
  logic [bbi_pkg::CIDX_W-1:0] cfg_index    = '0;
  logic [bbi_pkg::CFG_W-1:0]  cfg_data     = '0;
  logic                       in_valid     = 1'b0;
  logic                       in_stall;
  logic                       in_bit       = 1'b0;
  logic                       result_valid;
  logic                       result_stall = 1'b0;
  logic                       out_bit;
  logic                       out_valid;
  logic                       out_last;

  // Predictor state: configuration copy, both banks, frame progress
  logic [bbi_pkg::CFG_W-1:0]  pred_frame_cfg;
  logic [1:0]                 pred_msel;
  logic                       pred_dir;
  logic                       bank_mem [0:1][0:MAX_FRAME-1];
  logic [12:0]                frame_pos;
  logic [12:0]                prev_perm;
  logic                       fill_bank;
  logic                       frame_held;

  bit_result_t                expected_q [$];
  bit_result_t                oldest_exp;
  stim_row_t                  stim_plan [$];
  int                         mismatches  = 0;
  int                         result_idx  = 0;
  int                         idle_cycles = 0;
  int                         random_sent = 0;
  int                         phase_len;
  logic                       calm        = 1'b0;
  logic [bbi_pkg::CFG_W-1:0]  rand_frame;
  int                         pick;

  block_bit_interleaver #(
    .MAX_FRAME(MAX_FRAME)
  ) u_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_bit      (in_bit),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .out_bit     (out_bit),
    .out_valid   (out_valid),
    .out_last    (out_last)
  );

  always #5 clk = ~clk;

  // Effective frame length after clamping
  function automatic int unsigned frame_len();
    int unsigned n;
    n = 32'(pred_frame_cfg);
    if (n < bbi_pkg::FRAME_MIN) n = bbi_pkg::FRAME_MIN;
    if (n > MAX_FRAME) n = MAX_FRAME;
    return n;
  endfunction

  function automatic int unsigned mult_factor();
    case (pred_msel)
      bbi_pkg::MSEL_13: return 32'(bbi_pkg::MULT_13);
      bbi_pkg::MSEL_21: return 32'(bbi_pkg::MULT_21);
      default:          return 32'(bbi_pkg::MULT_5);
    endcase
  endfunction

  // Next permutation index: LCG mod s, skipping values outside the frame
  function automatic logic [12:0] next_perm_index(int unsigned prev, int unsigned n,
                                                  int unsigned pos);
    int unsigned s, q, v, tries, t0;
    s = 1;
    while (s <= n) s = s * 2;
    q = s / 4 - 1;
    t0 = mult_factor();
    v = (t0 * (prev & (s - 1)) + q) & (s - 1);
    tries = 0;
    while (v >= n) begin
      if (tries >= s) return (pos < n) ? pos[12:0] : 13'd0;
      v = (t0 * v + q) & (s - 1);
      tries++;
    end
    return v[12:0];
  endfunction

  // Advance the predictor by one input bit and return the output it causes
  function automatic bit_result_t interleave_bit(logic b);
    int unsigned n, p, perm, waddr, raddr;
    bit_result_t r;
    n = frame_len();
    p = 32'(frame_pos);
    perm = (p == 0) ? 0 : 32'(next_perm_index(32'(prev_perm), n, p));
    if (pred_dir == bbi_pkg::DIR_INTERLEAVE) begin
      waddr = p;
      raddr = perm;
    end else begin
      waddr = perm;
      raddr = p;
    end
    r.out_bit = frame_held ? bank_mem[~fill_bank][raddr] : 1'b0;
    bank_mem[fill_bank][waddr] = b;
    r.out_valid = frame_held;
    r.out_last = (p >= n - 1);
    if (r.out_last) begin
      frame_pos = '0;
      prev_perm = '0;
      fill_bank = ~fill_bank;
      frame_held = 1'b1;
    end else begin
      frame_pos = 13'(p + 1);
      prev_perm = 13'(perm);
    end
    return r;
  endfunction

  function automatic void plan_write(logic [bbi_pkg::CIDX_W-1:0] idx,
                                     logic [bbi_pkg::CFG_W-1:0] val);
    stim_row_t row;
    row = '{kind: ROW_WRITE, reg_idx: idx, reg_val: val, count: 0, typed: 1'b0,
            fixed_bit: 1'b0, typed_exp: '0};
    stim_plan.push_back(row);
  endfunction

  function automatic void plan_bits(int count);
    stim_row_t row;
    row = '{kind: ROW_BITS, reg_idx: '0, reg_val: '0, count: count, typed: 1'b0,
            fixed_bit: 1'b0, typed_exp: '0};
    stim_plan.push_back(row);
  endfunction

  function automatic void plan_typed(logic b, bit_result_t exp_r);
    stim_row_t row;
    row = '{kind: ROW_BITS, reg_idx: '0, reg_val: '0, count: 1, typed: 1'b1,
            fixed_bit: b, typed_exp: exp_r};
    stim_plan.push_back(row);
  endfunction

  // Stop sending and wait until every pending result transaction is back
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_q.size() != 0);
  endtask

  // Register write while the block is idle
  task automatic write_reg(logic [bbi_pkg::CIDX_W-1:0] idx, logic [bbi_pkg::CFG_W-1:0] val);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      bbi_pkg::CFG_FRAME_SIZE: pred_frame_cfg = val;
      bbi_pkg::CFG_MULT_SEL:   pred_msel = val[1:0];
      bbi_pkg::CFG_DIRECTION:  pred_dir = val[0];
      default: ;
    endcase
    cfg_we <= 1'b0;
  endtask

  // Send one bit; valid stays up until the transaction is accepted
  task automatic send_bit(logic b, logic typed, bit_result_t typed_exp);
    bit_result_t r;
    while (!calm && $urandom_range(0, 99) < 33) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_bit   <= b;
    do @(posedge clk); while (in_stall);
    r = interleave_bit(b);
    expected_q.push_back(typed ? typed_exp : r);
  endtask

  // Receiver back-pressure
  always @(posedge clk) begin
    result_stall <= !calm && ($urandom_range(0, 99) < 33);
  end

  // Compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (expected_q.size() == 0) begin
        if (mismatches < REPORT_LIMIT)
          $display("unexpected result transaction: bit=%0b valid=%0b last=%0b",
                   out_bit, out_valid, out_last);
        mismatches++;
      end else begin
        oldest_exp = expected_q.pop_front();
        if (oldest_exp.out_bit !== out_bit || oldest_exp.out_valid !== out_valid ||
            oldest_exp.out_last !== out_last) begin
          if (mismatches < REPORT_LIMIT)
            $display("result %0d: bit/valid/last expected %0b/%0b/%0b, got %0b/%0b/%0b",
                     result_idx, oldest_exp.out_bit, oldest_exp.out_valid,
                     oldest_exp.out_last, out_bit, out_valid, out_last);
          mismatches++;
        end
        result_idx++;
      end
    end
  end

  // Watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (result_valid && !result_stall) || rst)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    pred_frame_cfg = bbi_pkg::FRAME_SIZE_RESET;
    pred_msel      = bbi_pkg::MSEL_5;
    pred_dir       = bbi_pkg::DIR_INTERLEAVE;
    frame_pos      = '0;
    prev_perm      = '0;
    fill_bank      = 1'b0;
    frame_held     = 1'b0;
    for (int k = 0; k < MAX_FRAME; k++) begin
      bank_mem[0][k] = 1'b0;
      bank_mem[1][k] = 1'b0;
    end

    // First frame after reset has nothing to read. Two full frames at the
    // prefill size write both banks below that depth; every later frame
    // reads only below it
    plan_typed(1'b1, '{out_bit: 1'b0, out_valid: 1'b0, out_last: 1'b0});
    plan_typed(1'b0, '{out_bit: 1'b0, out_valid: 1'b0, out_last: 1'b0});
    plan_write(bbi_pkg::CFG_FRAME_SIZE, 14'(PREFILL));
    plan_bits(PREFILL - 3);
    plan_typed(1'b1, '{out_bit: 1'b0, out_valid: 1'b0, out_last: 1'b1});
    plan_bits(PREFILL);
    // Small frames: low clamp, multipliers 5 and 13, selector 3 falls back to 5
    plan_write(bbi_pkg::CFG_FRAME_SIZE, '0);
    plan_bits(4);
    plan_write(bbi_pkg::CFG_MULT_SEL, 14'(bbi_pkg::MSEL_13));
    plan_bits(5);
    plan_write(bbi_pkg::CFG_MULT_SEL, 14'd3);
    plan_bits(3);
    // Direction flipped mid-frame, then a whole deinterleaved frame
    plan_write(bbi_pkg::CFG_MULT_SEL, 14'(bbi_pkg::MSEL_21));
    plan_write(bbi_pkg::CFG_FRAME_SIZE, 14'd7);
    plan_bits(3);
    plan_write(bbi_pkg::CFG_DIRECTION, 14'(bbi_pkg::DIR_DEINTERLEAVE));
    plan_bits(11);
    // High clamp for a few deinterleaved bits (reads stay at low positions),
    // then the frame shrunk below the current position ends at once
    plan_write(bbi_pkg::CFG_FRAME_SIZE, '1);
    plan_bits(6);
    plan_write(bbi_pkg::CFG_FRAME_SIZE, 14'd5);
    plan_bits(5);
    plan_write(bbi_pkg::CFG_DIRECTION, 14'(bbi_pkg::DIR_INTERLEAVE));
    plan_write(bbi_pkg::CFG_MULT_SEL, 14'(bbi_pkg::MSEL_5));
    plan_bits(4);

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed plan
    foreach (stim_plan[i]) begin
      if (stim_plan[i].kind == ROW_WRITE) begin
        write_reg(stim_plan[i].reg_idx, stim_plan[i].reg_val);
      end else begin
        repeat (stim_plan[i].count)
          send_bit(stim_plan[i].typed ? stim_plan[i].fixed_bit : 1'($urandom_range(0, 1)),
                   stim_plan[i].typed, stim_plan[i].typed_exp);
      end
    end

    // Random phases: new settings between bursts, frames within the prefill depth
    while (random_sent < RANDOM_BITS) begin
      if ($urandom_range(0, 1) == 1) begin
        pick = $urandom_range(0, 99);
        if (pick < 60)      rand_frame = 14'($urandom_range(4, 40));
        else if (pick < 90) rand_frame = 14'($urandom_range(41, PREFILL));
        else                rand_frame = 14'($urandom_range(0, 3));
        write_reg(bbi_pkg::CFG_FRAME_SIZE, rand_frame);
      end
      if ($urandom_range(0, 2) == 0)
        write_reg(bbi_pkg::CFG_MULT_SEL, 14'($urandom_range(0, 3)));
      if ($urandom_range(0, 3) == 0)
        write_reg(bbi_pkg::CFG_DIRECTION, 14'($urandom_range(0, 1)));
      calm = (random_sent >= 400 && random_sent < 700);
      phase_len = $urandom_range(1, 150);
      repeat (phase_len) send_bit(1'($urandom_range(0, 1)), 1'b0, '0);
      random_sent += phase_len;
    end
    calm = 1'b0;

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
